// File: hw/rtl/stma_pkg.sv
package stma_pkg;

    // Store geometry and field widths.
    localparam int DEPTH_DEF = 32;
    localparam int MAX_DIM   = 256;
    localparam int DIM_W     = 9;
    localparam int ROW_W     = 8;
    localparam int COL_W     = 8;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = 17;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = ROW_W + COL_W + VAL_W;
    localparam int M_DATA_W  = 40;
    localparam int M_PAD_W   = M_DATA_W - (ROW_W + COL_W + SUM_W);

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_MERGE,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic step;
        logic emit_err;
        logic emit_fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dims_match;
        logic merge_done;
        logic push_needed;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/stma_ctrl.sv
module stma_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic [stma_pkg::KIND_W-1:0] i_kind,
    input  stma_pkg::t_status        i_status,
    output logic                     o_s_tready,
    output stma_pkg::t_cmd           o_cmd
);
    import stma_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_kind == KIND_LOAD_A) begin
                        o_cmd.load_a = 1'b1;
                    end else if (i_kind == KIND_LOAD_B) begin
                        o_cmd.load_b = 1'b1;
                    end else if (i_kind == KIND_RUN) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_START;
                    end
                end
            end
            S_START: begin
                if (i_status.dims_match) begin
                    n_state = S_READ;
                end else if (i_status.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_READ: begin
                n_state = i_status.merge_done ? S_FINISH : S_MERGE;
            end
            S_MERGE: begin
                // A new candidate displaces the held result, which then needs the output.
                if (!i_status.push_needed || i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit_fin = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/stma_dp.sv
module stma_dp #(
    parameter int DEPTH = stma_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [stma_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                          i_cfg_valid,
    input  logic [stma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stma_pkg::DIM_W-1:0]    i_cfg_data,
    input  stma_pkg::t_cmd                i_cmd,
    output stma_pkg::t_status             o_status,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [stma_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic [stma_pkg::STATUS_W-1:0] o_m_tuser,
    output logic                          o_m_tlast
);
    import stma_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Configured shapes.
    logic [DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;

    // Triplet stores: row in the low byte, column next, value on top.
    logic [S_DATA_W-1:0] mem_a [DEPTH];
    logic [S_DATA_W-1:0] mem_b [DEPTH];
    logic [S_DATA_W-1:0] r_x, r_y;

    logic [CW-1:0] r_cnt_a, r_cnt_b, r_i, r_j;

    // Held result, sent on once the next one is known (or with last at the end).
    logic             r_h_valid;
    logic [ROW_W-1:0] r_h_row;
    logic [COL_W-1:0] r_h_col;
    logic [SUM_W-1:0] r_h_val;

    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [ROW_W-1:0]    r_o_row;
    logic [COL_W-1:0]    r_o_col;
    logic [SUM_W-1:0]    r_o_val;
    logic                r_o_last;

    logic [ROW_W-1:0] x_row, y_row;
    logic [COL_W-1:0] x_col, y_col;
    logic [VAL_W-1:0] x_val, y_val;
    logic [SUM_W-1:0] sum;
    logic             a_done, b_done, take_a, take_b, take_both, cand_valid;
    logic [ROW_W-1:0] c_row;
    logic [COL_W-1:0] c_col;
    logic [SUM_W-1:0] c_val;
    logic             out_free, out_load, push_held;

    assign x_row = r_x[ROW_W-1:0];
    assign x_col = r_x[ROW_W+COL_W-1:ROW_W];
    assign x_val = r_x[S_DATA_W-1:ROW_W+COL_W];
    assign y_row = r_y[ROW_W-1:0];
    assign y_col = r_y[ROW_W+COL_W-1:ROW_W];
    assign y_val = r_y[S_DATA_W-1:ROW_W+COL_W];

    assign a_done = (r_i >= r_cnt_a);
    assign b_done = (r_j >= r_cnt_b);
    assign take_a = !a_done && (b_done || (x_row < y_row) ||
                    ((x_row == y_row) && (x_col < y_col)));
    assign take_b = !b_done && (a_done || (x_row > y_row) ||
                    ((x_row == y_row) && (x_col > y_col)));
    assign take_both = !a_done && !b_done && !take_a && !take_b;
    assign sum = $signed({x_val[VAL_W-1], x_val}) + $signed({y_val[VAL_W-1], y_val});
    assign cand_valid = take_a || take_b || (sum != '0);

    always_comb begin
        if (take_a) begin
            c_row = x_row;
            c_col = x_col;
            c_val = {x_val[VAL_W-1], x_val};
        end else if (take_b) begin
            c_row = y_row;
            c_col = y_col;
            c_val = {y_val[VAL_W-1], y_val};
        end else begin
            c_row = x_row;
            c_col = x_col;
            c_val = sum;
        end
    end

    assign out_free  = !r_o_valid || i_m_tready;
    assign push_held = i_cmd.step && cand_valid && r_h_valid;
    assign out_load  = push_held || i_cmd.emit_err || i_cmd.emit_fin;

    assign o_status.dims_match  = (r_a_rows == r_b_rows) && (r_a_cols == r_b_cols);
    assign o_status.merge_done  = a_done && b_done;
    assign o_status.push_needed = cand_valid && r_h_valid;
    assign o_status.out_free    = out_free;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows  <= DIM_W'(MAX_DIM);
            r_a_cols  <= DIM_W'(MAX_DIM);
            r_b_rows  <= DIM_W'(MAX_DIM);
            r_b_cols  <= DIM_W'(MAX_DIM);
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_h_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_A_ROWS: r_a_rows <= i_cfg_data;
                    CFG_A_COLS: r_a_cols <= i_cfg_data;
                    CFG_B_ROWS: r_b_rows <= i_cfg_data;
                    CFG_B_COLS: r_b_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_a && (r_cnt_a < CW'(DEPTH))) begin
                r_cnt_a <= r_cnt_a + 1'b1;
            end
            if (i_cmd.load_b && (r_cnt_b < CW'(DEPTH))) begin
                r_cnt_b <= r_cnt_b + 1'b1;
            end
            if (i_cmd.start) begin
                r_i       <= '0;
                r_j       <= '0;
                r_h_valid <= 1'b0;
            end
            if (i_cmd.step) begin
                if (take_a || take_both) begin
                    r_i <= r_i + 1'b1;
                end
                if (take_b || take_both) begin
                    r_j <= r_j + 1'b1;
                end
                if (cand_valid) begin
                    r_h_valid <= 1'b1;
                end
            end
            if (i_cmd.emit_err || i_cmd.emit_fin) begin
                r_cnt_a   <= '0;
                r_cnt_b   <= '0;
                r_i       <= '0;
                r_j       <= '0;
                r_h_valid <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Stores: one write port each, registered read at the merge index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && (r_cnt_a < CW'(DEPTH))) begin
            mem_a[r_cnt_a[IW-1:0]] <= i_s_tdata;
        end
        if (i_cmd.load_b && (r_cnt_b < CW'(DEPTH))) begin
            mem_b[r_cnt_b[IW-1:0]] <= i_s_tdata;
        end
        r_x <= mem_a[r_i[IW-1:0]];
        r_y <= mem_b[r_j[IW-1:0]];
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && cand_valid) begin
            r_h_row <= c_row;
            r_h_col <= c_col;
            r_h_val <= c_val;
        end
        if (push_held || (i_cmd.emit_fin && r_h_valid)) begin
            r_o_status <= ST_ENTRY;
            r_o_row    <= r_h_row;
            r_o_col    <= r_h_col;
            r_o_val    <= r_h_val;
            r_o_last   <= i_cmd.emit_fin;
        end else if (i_cmd.emit_fin || i_cmd.emit_err) begin
            r_o_status <= i_cmd.emit_err ? ST_MISMATCH : ST_EMPTY;
            r_o_row    <= '0;
            r_o_col    <= '0;
            r_o_val    <= '0;
            r_o_last   <= 1'b1;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{M_PAD_W{1'b0}}, r_o_val, r_o_col, r_o_row};
    assign o_m_tuser  = r_o_status;
    assign o_m_tlast  = r_o_last;

endmodule

// File: hw/rtl/sparse_triplet_matrix_add_core.sv
// Channel | Direction | Handshake              | Payload
// s       | in        | i_s_tvalid/o_s_tready  | tdata: row, col, value; tuser: kind
// m       | out       | o_m_tvalid/i_m_tready  | tdata: out_row, out_col, out_value;
//         |           |                        | tuser: status; tlast: last
// cfg     | in        | i_cfg_valid/o_cfg_ready| index, 9-bit data
//
// Loads are taken back to back while idle. A run checks the shapes in a start state,
// then does up to 2 * DEPTH merge steps, each reading both stores in a read state
// and comparing and advancing in a merge state; a last read sees both lists end and
// a finish state posts the final result. A shape mismatch is posted in the start state.
// The output register may stall the merge whenever a new result needs it, and the
// final or mismatch result waits for it as well.
// Reset is synchronous and active low; it clears both counts and sets all
// shape registers to the maximum dimension. Stores hold no reset value.
module sparse_triplet_matrix_add_core #(
    parameter int DEPTH = stma_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [7:0] row, [15:8] col, [31:16] value
    input  logic [stma_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [1:0] kind
    input  logic [stma_pkg::KIND_W-1:0]    i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] out_row, [15:8] out_col, [32:16] out_value, [39:33] zero
    output logic [stma_pkg::M_DATA_W-1:0]  o_m_tdata,
    // [1:0] status
    output logic [stma_pkg::STATUS_W-1:0]  o_m_tuser,
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [stma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stma_pkg::DIM_W-1:0]     i_cfg_data
);
    import stma_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Shape registers are plain flops, so a write is always taken.
    assign o_cfg_ready = 1'b1;

    stma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    stma_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// File: hw/rtl/stma_checker.sv
module stma_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [stma_pkg::KIND_W-1:0]    i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [stma_pkg::M_DATA_W-1:0]  o_m_tdata,
    input logic [stma_pkg::STATUS_W-1:0]  o_m_tuser,
    input logic                           o_m_tlast
);
    import stma_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // Mismatch and empty results stand alone and end the run.
    a_special_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_ENTRY) |-> o_m_tlast)
        else $error("special result without last");

    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_ENTRY) |-> (o_m_tdata == '0))
        else $error("special result with nonzero payload");

    // A run occupies the block for at least the next cycle.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == KIND_RUN) |=> !o_s_tready)
        else $error("input taken right after a run");

endmodule

bind sparse_triplet_matrix_add_core stma_checker u_stma_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import stma_pkg::*;

    localparam int STORE_DEPTH  = DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 80;
    // The one kind code that the block must ignore.
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

    // One stored matrix entry, as the block keeps it.
    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_term;

    // One result transfer on the master side.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [SUM_W-1:0]    value;
        logic                last;
    } t_sum;

    typedef enum logic {ROW_ITEM, ROW_SHAPE} t_script_op;

    // A row of the directed script. Shape rows carry all four dimensions,
    // indexed by register index. Typed rows carry the status that a run must give.
    typedef struct packed {
        t_script_op                 op;
        logic [KIND_W-1:0]          kind;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic [VAL_W-1:0]           value;
        logic                       typed;
        logic [STATUS_W-1:0]        status;
        logic [3:0][DIM_W-1:0]      dims;
    } t_script_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [S_DATA_W-1:0]     i_s_tdata;
    logic [KIND_W-1:0]       i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [M_DATA_W-1:0]     o_m_tdata;
    logic [STATUS_W-1:0]     o_m_tuser;
    logic                    o_m_tlast;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [DIM_W-1:0]        i_cfg_data;

    // Travels beside each input transfer: set when the run's status is typed in.
    logic                    item_typed;
    logic [STATUS_W-1:0]     item_typed_status;

    // Predictor state: shape registers, both stores and their fill counts.
    logic [DIM_W-1:0]        dims_now [4] = '{default: DIM_W'(MAX_DIM)};
    t_term                   first_terms [STORE_DEPTH];
    t_term                   second_terms [STORE_DEPTH];
    int                      first_used = 0;
    int                      second_used = 0;

    t_sum                    run_sums [$];
    t_sum                    pending_sums [$];

    // Stimulus side bookkeeping.
    logic [3:0][DIM_W-1:0]   cur_dims = {4{9'(MAX_DIM)}};
    logic [15:0]             draft_keys [$];
    logic [VAL_W-1:0]        draft_vals [$];
    logic [15:0]             first_keys [$];
    logic [VAL_W-1:0]        first_vals [$];
    logic [15:0]             second_keys [$];
    logic [VAL_W-1:0]        second_vals [$];
    t_script_row             script [];
    bit                      steady = 1'b0;
    int                      random_items = 0;
    int                      cycles = 0;
    int                      errors = 0;

    sparse_triplet_matrix_add_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string what);
        $display("[cycle %0d] mismatch: %s", cycles, what);
        errors++;
    endtask

    // Merges both stored lists the way the block does and leaves the results
    // of one run in run_sums. Both stores are emptied, whatever the outcome.
    function automatic void add_stored_matrices();
        int          i;
        int          j;
        int          total;
        bit          take_first;
        bit          take_second;
        logic [15:0] key_first;
        logic [15:0] key_second;
        t_sum        one;
        run_sums.delete();
        i = 0;
        j = 0;
        if (dims_now[CFG_A_ROWS] != dims_now[CFG_B_ROWS] ||
            dims_now[CFG_A_COLS] != dims_now[CFG_B_COLS]) begin
            one = '0;
            one.status = ST_MISMATCH;
            one.last = 1'b1;
            run_sums.push_back(one);
            first_used = 0;
            second_used = 0;
            return;
        end
        while (i < first_used || j < second_used) begin
            if (i >= first_used) begin
                take_first = 1'b0;
                take_second = 1'b1;
            end else if (j >= second_used) begin
                take_first = 1'b1;
                take_second = 1'b0;
            end else begin
                // Row in the high byte, so one compare orders by row, then column.
                key_first = {first_terms[i].row, first_terms[i].col};
                key_second = {second_terms[j].row, second_terms[j].col};
                take_first = (key_first <= key_second);
                take_second = (key_second <= key_first);
            end
            one = '0;
            one.status = ST_ENTRY;
            if (take_first) begin
                one.row = first_terms[i].row;
                one.col = first_terms[i].col;
                total = int'(first_terms[i].value);
                if (take_second) begin
                    total += int'(second_terms[j].value);
                end
            end else begin
                one.row = second_terms[j].row;
                one.col = second_terms[j].col;
                total = int'(second_terms[j].value);
            end
            one.value = total[SUM_W-1:0];
            // A coinciding pair that cancels is consumed silently; a lone zero
            // entry still passes through.
            if (total != 0 || !(take_first && take_second)) begin
                run_sums.push_back(one);
            end
            if (take_first) begin
                i++;
            end
            if (take_second) begin
                j++;
            end
        end
        first_used = 0;
        second_used = 0;
        if (run_sums.size() == 0) begin
            one = '0;
            one.status = ST_EMPTY;
            one.last = 1'b1;
            run_sums.push_back(one);
        end else begin
            one = run_sums.pop_back();
            one.last = 1'b1;
            run_sums.push_back(one);
        end
    endfunction

    // Follows every accepted input and register transfer and keeps the
    // predictor in step with the block.
    always @(posedge i_clk) begin : track_inputs
        t_term incoming;
        t_sum  flagged;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            dims_now[i_cfg_index] = i_cfg_data;
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            incoming.row = i_s_tdata[7:0];
            incoming.col = i_s_tdata[15:8];
            incoming.value = i_s_tdata[31:16];
            case (i_s_tuser)
                KIND_LOAD_A: begin
                    // A load into a full store is dropped.
                    if (first_used < STORE_DEPTH) begin
                        first_terms[first_used] = incoming;
                        first_used++;
                    end
                end
                KIND_LOAD_B: begin
                    if (second_used < STORE_DEPTH) begin
                        second_terms[second_used] = incoming;
                        second_used++;
                    end
                end
                KIND_RUN: begin
                    add_stored_matrices();
                    if (item_typed) begin
                        flagged = '0;
                        flagged.status = item_typed_status;
                        flagged.last = 1'b1;
                        pending_sums.push_back(flagged);
                    end else begin
                        while (run_sums.size() != 0) begin
                            pending_sums.push_back(run_sums.pop_front());
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Compares every result transfer with the oldest expected one.
    always @(posedge i_clk) begin : compare_results
        t_sum want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_sums.size() == 0) begin
                note_mismatch($sformatf("result with nothing expected, status %0d", o_m_tuser));
            end else begin
                want = pending_sums.pop_front();
                if (o_m_tuser !== want.status) begin
                    note_mismatch($sformatf("status %0d, want %0d", o_m_tuser, want.status));
                end
                if (o_m_tdata[7:0] !== want.row) begin
                    note_mismatch($sformatf("row %0d, want %0d", o_m_tdata[7:0], want.row));
                end
                if (o_m_tdata[15:8] !== want.col) begin
                    note_mismatch($sformatf("col %0d, want %0d", o_m_tdata[15:8], want.col));
                end
                if (o_m_tdata[32:16] !== want.value) begin
                    note_mismatch($sformatf("value %0d, want %0d",
                        $signed(o_m_tdata[32:16]), $signed(want.value)));
                end
                if (o_m_tlast !== want.last) begin
                    note_mismatch($sformatf("last %0d, want %0d", o_m_tlast, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    // The result side stalls a random number of cycles before each transfer.
    initial begin : accept_results
        int gap;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    // Sends one input transfer after a random gap. tvalid stays high after the
    // transfer, so back-to-back items never drop it within one time step.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [VAL_W-1:0] value,
                             input logic typed, input logic [STATUS_W-1:0] status);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {value, col, row};
        i_s_tuser <= kind;
        item_typed <= typed;
        item_typed_status <= status;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Waits until every expected result has arrived and the block has had
    // time to fall back to idle.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four shape registers back to back. Only called while idle.
    task automatic set_shape(input logic [3:0][DIM_W-1:0] dims);
        for (int r = CFG_A_ROWS; r <= CFG_B_COLS; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(r);
            i_cfg_data <= dims[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cur_dims = dims;
    endtask

    function automatic t_script_row put_item(input logic [KIND_W-1:0] kind,
                                             input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] col,
                                             input logic [VAL_W-1:0] value);
        t_script_row r;
        r = '0;
        r.op = ROW_ITEM;
        r.kind = kind;
        r.row = row;
        r.col = col;
        r.value = value;
        return r;
    endfunction

    function automatic t_script_row run_gives(input logic [STATUS_W-1:0] status);
        t_script_row r;
        r = put_item(KIND_RUN, '0, '0, '0);
        r.typed = 1'b1;
        r.status = status;
        return r;
    endfunction

    function automatic t_script_row reshape(input logic [DIM_W-1:0] a_rows,
                                            input logic [DIM_W-1:0] a_cols,
                                            input logic [DIM_W-1:0] b_rows,
                                            input logic [DIM_W-1:0] b_cols);
        t_script_row r;
        r = '0;
        r.op = ROW_SHAPE;
        r.dims[CFG_A_ROWS] = a_rows;
        r.dims[CFG_A_COLS] = a_cols;
        r.dims[CFG_B_ROWS] = b_rows;
        r.dims[CFG_B_COLS] = b_cols;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 3))
            0: return 9'd1;
            1: return DIM_W'(MAX_DIM);
            default: return DIM_W'($urandom_range(1, MAX_DIM));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;   // zero loads are not rejected by the block
            default: return VAL_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // Row in the high byte, column in the low byte. One pick in ten ignores
    // the shape entirely.
    function automatic logic [15:0] pick_position(input logic [DIM_W-1:0] rows,
                                                  input logic [DIM_W-1:0] cols);
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        if ($urandom_range(0, 9) == 0) begin
            r = ROW_W'($urandom);
            c = COL_W'($urandom);
        end else begin
            r = ROW_W'($urandom_range(0, rows - 1));
            c = COL_W'($urandom_range(0, cols - 1));
        end
        return {r, c};
    endfunction

    // Inserts a position into the sorted draft list unless it is there already.
    function automatic bit add_position(input logic [15:0] key, input logic [VAL_W-1:0] value);
        int p;
        p = 0;
        while (p < draft_keys.size() && draft_keys[p] < key) p++;
        if (p < draft_keys.size() && draft_keys[p] == key) begin
            return 1'b0;
        end
        draft_keys.insert(p, key);
        draft_vals.insert(p, value);
        return 1'b1;
    endfunction

    // One random phase: maybe a new shape, two sorted lists that partly share
    // positions (some of them cancelling), loads interleaved at random, then a run.
    task automatic play_phase(input bit overfill);
        int                    n_first;
        int                    n_second;
        int                    tries;
        int                    ia;
        int                    ib;
        bit                    fill_first;
        logic [3:0][DIM_W-1:0] dims;
        logic [15:0]           swap_key;
        logic [VAL_W-1:0]      swap_val;
        steady = ($urandom_range(0, 3) == 0);
        if (overfill || $urandom_range(0, 2) == 0) begin
            dims[CFG_A_ROWS] = overfill ? DIM_W'(MAX_DIM) : pick_dim();
            dims[CFG_A_COLS] = overfill ? DIM_W'(MAX_DIM) : pick_dim();
            dims[CFG_B_ROWS] = dims[CFG_A_ROWS];
            dims[CFG_B_COLS] = dims[CFG_A_COLS];
            // Now and then the shapes disagree in one dimension.
            if (!overfill && $urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1)) begin
                    dims[CFG_B_ROWS] = pick_dim();
                end else begin
                    dims[CFG_B_COLS] = pick_dim();
                end
            end
            settle();
            set_shape(dims);
        end

        fill_first = $urandom_range(0, 1);
        n_first = (overfill && fill_first) ? STORE_DEPTH + 2 : $urandom_range(0, 6);
        n_second = (overfill && !fill_first) ? STORE_DEPTH + 2 : $urandom_range(0, 6);

        draft_keys.delete();
        draft_vals.delete();
        tries = 0;
        while (draft_keys.size() < n_first && tries < 8 * n_first) begin
            void'(add_position(pick_position(cur_dims[CFG_A_ROWS], cur_dims[CFG_A_COLS]),
                               pick_value()));
            tries++;
        end
        first_keys = draft_keys;
        first_vals = draft_vals;

        // The second list reuses about half of the first list's positions.
        draft_keys.delete();
        draft_vals.delete();
        foreach (first_keys[k]) begin
            if (draft_keys.size() < n_second && $urandom_range(0, 1)) begin
                void'(add_position(first_keys[k],
                    ($urandom_range(0, 2) == 0) ? -first_vals[k] : pick_value()));
            end
        end
        tries = 0;
        while (draft_keys.size() < n_second && tries < 8 * n_second) begin
            void'(add_position(pick_position(cur_dims[CFG_B_ROWS], cur_dims[CFG_B_COLS]),
                               pick_value()));
            tries++;
        end
        second_keys = draft_keys;
        second_vals = draft_vals;

        // An occasional swap leaves the first list out of order.
        if (first_keys.size() > 1 && $urandom_range(0, 7) == 0) begin
            ia = $urandom_range(0, first_keys.size() - 1);
            ib = $urandom_range(0, first_keys.size() - 1);
            swap_key = first_keys[ia];
            swap_val = first_vals[ia];
            first_keys[ia] = first_keys[ib];
            first_vals[ia] = first_vals[ib];
            first_keys[ib] = swap_key;
            first_vals[ib] = swap_val;
        end

        ia = 0;
        ib = 0;
        while (ia < first_keys.size() || ib < second_keys.size()) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(KIND_IGNORED, ROW_W'($urandom), COL_W'($urandom),
                          VAL_W'($urandom), 1'b0, ST_ENTRY);
            end
            if (ib >= second_keys.size() || (ia < first_keys.size() && $urandom_range(0, 1))) begin
                send_item(KIND_LOAD_A, first_keys[ia][15:8], first_keys[ia][7:0],
                          first_vals[ia], 1'b0, ST_ENTRY);
                ia++;
            end else begin
                send_item(KIND_LOAD_B, second_keys[ib][15:8], second_keys[ib][7:0],
                          second_vals[ib], 1'b0, ST_ENTRY);
                ib++;
            end
            random_items++;
        end
        // The payload of a run transfer carries no meaning.
        send_item(KIND_RUN, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom),
                  1'b0, ST_ENTRY);
        random_items++;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= KIND_LOAD_A;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_A_ROWS;
        i_cfg_data <= '0;
        item_typed <= 1'b0;
        item_typed_status <= ST_ENTRY;

        script = '{
            // Right after reset both stores are empty and the shapes agree.
            run_gives(ST_EMPTY),
            // Largest positive and negative sums, a zero load passing through,
            // a cancelling pair, and a kind the block must ignore.
            put_item(KIND_LOAD_A, 8'd0, 8'd0, 16'h7FFF),
            put_item(KIND_LOAD_B, 8'd0, 8'd0, 16'h7FFF),
            put_item(KIND_LOAD_A, 8'd1, 8'd200, 16'h0000),
            put_item(KIND_LOAD_B, 8'd2, 8'd0, 16'h0007),
            put_item(KIND_LOAD_A, 8'd3, 8'd4, 16'h0005),
            put_item(KIND_LOAD_B, 8'd3, 8'd4, 16'hFFFB),
            put_item(KIND_IGNORED, 8'd9, 8'd9, 16'h1234),
            put_item(KIND_LOAD_A, 8'd255, 8'd255, 16'h8000),
            put_item(KIND_LOAD_B, 8'd255, 8'd255, 16'h8000),
            put_item(KIND_RUN, 8'd0, 8'd0, 16'h0000),
            // Everything cancels, so the run reports an empty sum.
            put_item(KIND_LOAD_A, 8'd10, 8'd10, 16'h0064),
            put_item(KIND_LOAD_B, 8'd10, 8'd10, 16'hFF9C),
            run_gives(ST_EMPTY),
            // First list loaded out of order.
            put_item(KIND_LOAD_A, 8'd5, 8'd5, 16'h0001),
            put_item(KIND_LOAD_A, 8'd0, 8'd1, 16'h0002),
            put_item(KIND_LOAD_B, 8'd3, 8'd3, 16'h0003),
            put_item(KIND_RUN, 8'd0, 8'd0, 16'h0000),
            // Row counts disagree; the error run also empties the stores.
            reshape(9'd1, 9'd256, 9'd256, 9'd256),
            put_item(KIND_LOAD_A, 8'd0, 8'd0, 16'h0009),
            run_gives(ST_MISMATCH),
            reshape(9'd1, 9'd1, 9'd1, 9'd1),
            run_gives(ST_EMPTY),
            put_item(KIND_LOAD_A, 8'd0, 8'd0, 16'h0001),
            put_item(KIND_LOAD_B, 8'd0, 8'd0, 16'h0002),
            put_item(KIND_RUN, 8'd0, 8'd0, 16'h0000)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[n]) begin
            if (script[n].op == ROW_SHAPE) begin
                settle();
                set_shape(script[n].dims);
            end else begin
                send_item(script[n].kind, script[n].row, script[n].col, script[n].value,
                          script[n].typed, script[n].status);
            end
        end

        // One phase fills a store past its depth, the rest stay small.
        play_phase(1'b1);
        while (random_items < RANDOM_ITEMS) begin
            play_phase(1'b0);
        end

        settle();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
